[rtl/sliding_window_max_average_macros.svh]
// Assertion helpers shared by the block's modules.
`ifndef SLIDING_WINDOW_MAX_AVERAGE_MACROS_SVH
`define SLIDING_WINDOW_MAX_AVERAGE_MACROS_SVH

// Same-cycle implication, muted while reset is asserted.
`define SWMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, muted while reset is asserted.
`define SWMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/swma_pkg.sv]
package swma_pkg;

	localparam int SAMPLE_BITS     = 16;
	localparam int SUM_W           = 26;
	localparam int AVG_W           = 24;
	localparam int FRAC_W          = 8;
	localparam int CFG_W           = 11;
	localparam int DIV_W           = SUM_W + FRAC_W;
	localparam int WINDOW_MAX_DEF  = 1024;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [CFG_W-1:0] CFG_RESET   = CFG_W'(1);
	localparam logic [AVG_W-1:0] AVG_POS_MAX = {1'b0, {(AVG_W-1){1'b1}}};
	localparam logic [AVG_W-1:0] AVG_NEG_MIN = {1'b1, {(AVG_W-1){1'b0}}};

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
	} in_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] max_sum;
		logic signed [AVG_W-1:0] max_average;
		logic                    short_stream;
	} out_t;

	// One finished stream handed from the front to the divider.
	typedef struct packed {
		logic signed [SUM_W-1:0] best_sum;
		logic [CFG_W-1:0]        len;
		logic                    short_stream;
	} job_t;

endpackage

[rtl/swma_ram.sv]
module swma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/swma_fifo.sv]
`include "sliding_window_max_average_macros.svh"

module swma_fifo #(
	parameter int WIDTH = 38,
	parameter int DEPTH = swma_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SWMA_ASSERT_NOW(a_no_overflow, clk, arst_n, full, !push, "queue written while full")
	`SWMA_ASSERT_NOW(a_no_underflow, clk, arst_n, empty, !pop, "queue read while empty")

endmodule

[rtl/swma_front.sv]
`include "sliding_window_max_average_macros.svh"

module swma_front #(
	parameter int WINDOW_MAX = swma_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [swma_pkg::CFG_W-1:0]    len,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  swma_pkg::in_t                 in_word,
	output logic                          job_valid,
	input  logic                          job_ready,
	output swma_pkg::job_t                job
);

	localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int LEN_W = $clog2(WINDOW_MAX + 1);
	localparam int XW    = ((LEN_W > swma_pkg::CFG_W) ? LEN_W : swma_pkg::CFG_W) + 1;
	localparam int SW    = swma_pkg::SUM_W;

	typedef enum logic {
		ST_TAKE,
		ST_UPDATE
	} state_t;

	state_t                               state_q;
	logic [AW-1:0]                        wp_q;
	logic [LEN_W-1:0]                     fill_q;
	logic signed [SW-1:0]                 sum_q;
	logic signed [SW-1:0]                 best_q;
	logic                                 best_valid_q;
	logic signed [swma_pkg::SAMPLE_BITS-1:0] sample_s1;
	logic                                 last_s1;

	logic [XW-1:0]                        wp_x, len_x, fill_x, fill_nx, old_x;
	logic [AW-1:0]                        old_addr;
	logic [swma_pkg::SAMPLE_BITS-1:0]     old_data;
	logic [LEN_W-1:0]                     fill_next;
	logic                                 full_before, full_after;
	logic signed [SW-1:0]                 drop_val, sum_next, best_next;
	logic                                 best_valid_next;
	logic                                 advance;

	// Entry leaving the window sits len places behind the write pointer.
	always_comb begin
		wp_x   = XW'(wp_q);
		len_x  = XW'(len);
		old_x  = (wp_x >= len_x) ? wp_x - len_x : wp_x + XW'(WINDOW_MAX) - len_x;
		old_addr = AW'(old_x);
	end

	swma_ram #(
		.WIDTH(swma_pkg::SAMPLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_store (
		.clk  (clk),
		.we   (advance),
		.waddr(wp_q),
		.wdata(sample_s1),
		.raddr(old_addr),
		.rdata(old_data)
	);

	always_comb begin
		fill_x      = XW'(fill_q);
		full_before = (fill_x >= len_x);
		fill_next   = (fill_q == LEN_W'(WINDOW_MAX)) ? fill_q : fill_q + 1'b1;
		fill_nx     = XW'(fill_next);
		full_after  = (fill_nx >= len_x);
		drop_val    = full_before ? SW'($signed(old_data)) : '0;
		sum_next    = sum_q + SW'(sample_s1) - drop_val;
		best_next   = best_q;
		if (full_after && (!best_valid_q || (sum_next > best_q))) begin
			best_next = sum_next;
		end
		best_valid_next = best_valid_q | full_after;
	end

	// Hold in update while a finished stream waits for room in the queue.
	assign advance   = (state_q == ST_UPDATE) && (!last_s1 || job_ready);
	assign in_ready  = (state_q == ST_TAKE);
	assign job_valid = (state_q == ST_UPDATE) && last_s1;

	always_comb begin
		job.best_sum     = best_valid_next ? best_next : '0;
		job.len          = len;
		job.short_stream = !best_valid_next;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= in_word.sample;
			last_s1   <= in_word.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_TAKE;
			wp_q         <= '0;
			fill_q       <= '0;
			sum_q        <= '0;
			best_q       <= '0;
			best_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_TAKE: begin
					if (in_valid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (advance) begin
						state_q <= ST_TAKE;
						if (last_s1) begin
							wp_q         <= '0;
							fill_q       <= '0;
							sum_q        <= '0;
							best_q       <= '0;
							best_valid_q <= 1'b0;
						end else begin
							wp_q         <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + 1'b1;
							fill_q       <= fill_next;
							sum_q        <= sum_next;
							best_q       <= best_next;
							best_valid_q <= best_valid_next;
						end
					end
				end
				default: begin
					state_q <= ST_TAKE;
				end
			endcase
		end
	end

	`SWMA_ASSERT_NEXT(a_clear_after_last, clk, arst_n, job_valid && job_ready, (fill_q == '0) && (wp_q == '0) && !best_valid_q, "stream state not cleared after last word")
	`SWMA_ASSERT_NOW(a_short_has_no_sum, clk, arst_n, job_valid && job.short_stream, job.best_sum == '0, "short stream carries a sum")

endmodule

[rtl/swma_back.sv]
`include "sliding_window_max_average_macros.svh"

module swma_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_pop,
	input  swma_pkg::job_t  job,
	output logic            out_valid,
	input  logic            out_ready,
	output swma_pkg::out_t  out_word
);

	localparam int DW    = swma_pkg::DIV_W;
	localparam int LW    = swma_pkg::CFG_W;
	localparam int CNT_W = $clog2(DW + 1);
	localparam int AW    = swma_pkg::AVG_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIX,
		ST_SHOW
	} state_t;

	state_t                       state_q;
	logic [LW-1:0]                rem_q;
	logic [DW-1:0]                quo_q;
	logic [LW-1:0]                div_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         neg_q;
	logic signed [swma_pkg::SUM_W-1:0] sum_q;
	swma_pkg::out_t               res_q;

	logic signed [DW-1:0]         dividend;
	logic [DW-1:0]                mag;
	logic [LW:0]                  partial;
	logic                         ge;
	logic [LW-1:0]                rem_next;
	logic [AW-1:0]                avg_fix;

	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	assign out_valid = (state_q == ST_SHOW);
	assign out_word  = res_q;

	always_comb begin
		dividend = {job.best_sum, {swma_pkg::FRAC_W{1'b0}}};
		mag      = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
	end

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		partial  = {rem_q, quo_q[DW-1]};
		ge       = (partial >= {1'b0, div_q});
		rem_next = ge ? LW'(partial - {1'b0, div_q}) : LW'(partial);
	end

	// Apply the sign and clamp to the average's range.
	always_comb begin
		if (!neg_q) begin
			avg_fix = (quo_q > DW'(swma_pkg::AVG_POS_MAX)) ? swma_pkg::AVG_POS_MAX
				: AW'(quo_q);
		end else begin
			avg_fix = (quo_q > DW'(swma_pkg::AVG_NEG_MIN)) ? swma_pkg::AVG_NEG_MIN
				: AW'(-quo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q   <= '0;
			quo_q   <= '0;
			div_q   <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			sum_q   <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (job.short_stream) begin
							res_q.max_sum      <= '0;
							res_q.max_average  <= '0;
							res_q.short_stream <= 1'b1;
							state_q            <= ST_SHOW;
						end else begin
							rem_q   <= '0;
							quo_q   <= mag;
							div_q   <= job.len;
							cnt_q   <= CNT_W'(DW);
							neg_q   <= job.best_sum[swma_pkg::SUM_W-1];
							sum_q   <= job.best_sum;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					quo_q <= {quo_q[DW-2:0], ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					res_q.max_sum      <= sum_q;
					res_q.max_average  <= avg_fix;
					res_q.short_stream <= 1'b0;
					state_q            <= ST_SHOW;
				end
				ST_SHOW: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SWMA_ASSERT_NOW(a_short_zero, clk, arst_n, out_valid && out_word.short_stream, (out_word.max_sum == '0) && (out_word.max_average == '0), "short result has nonzero fields")
	`SWMA_ASSERT_NOW(a_avg_sign, clk, arst_n, out_valid && !out_word.short_stream, (out_word.max_average[AW-1] == out_word.max_sum[swma_pkg::SUM_W-1]) || (out_word.max_average == '0), "average sign disagrees with sum")

endmodule

[rtl/sliding_window_max_average.sv]
// Maximum-average sliding window over a stream of signed samples.
// Input channel in_valid/in_ready/in_word: one sample word per handshake, with
// a last flag that closes the stream. Output channel out_valid/out_ready/out_word:
// one result word per stream, the largest full-window sum, that sum times 256
// divided by the window length (truncated toward zero, saturated to 24 bits),
// and a short-stream flag set when no full window was seen.
// Config channel cfg_valid/cfg_data: write the window length; cfg_ready is
// always high. Write it only while the block is idle. Zero counts as one, and
// values above WINDOW_MAX count as WINDOW_MAX.
// Each sample word passes a take state, then an update state, as the ring store
// has a single registered read port (read the leaving entry, then add and write
// back); no new word is taken until the update is done. Results pass the queue
// and the back end's 34-step bit-serial divider; short streams skip the divider.
// A two-deep queue separates the sample front end from the divider, so a
// stalled receiver holds only the result; the front keeps taking words until
// a further last word finds the queue full.
// Reset clears stream state and sets the window length to one; the ring store
// is not cleared and needs no clearing pass.
module sliding_window_max_average #(
	parameter int WINDOW_MAX  = swma_pkg::WINDOW_MAX_DEF,
	parameter int QUEUE_DEPTH = swma_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [swma_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  swma_pkg::in_t              in_word,
	output logic                       out_valid,
	input  logic                       out_ready,
	output swma_pkg::out_t             out_word
);

	localparam int JOB_W = $bits(swma_pkg::job_t);

	logic [swma_pkg::CFG_W-1:0] window_len_q;
	logic [swma_pkg::CFG_W-1:0] len_eff;

	logic                       job_push, job_full, job_pop, job_empty;
	swma_pkg::job_t             job_in, job_out;
	logic [JOB_W-1:0]           job_rdata;

	// Config register: always ready, latch on handshake.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= swma_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_len_q <= cfg_data;
		end
	end

	// Clamp the length into 1..WINDOW_MAX.
	always_comb begin
		if (window_len_q == '0) begin
			len_eff = swma_pkg::CFG_W'(1);
		end else if (int'(window_len_q) > WINDOW_MAX) begin
			len_eff = swma_pkg::CFG_W'(WINDOW_MAX);
		end else begin
			len_eff = window_len_q;
		end
	end

	// Front: ring store, running sum and best sum per stream.
	swma_front #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.len      (len_eff),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word  (in_word),
		.job_valid(job_push),
		.job_ready(!job_full),
		.job      (job_in)
	);

	// Queue of finished streams waiting for the divider.
	swma_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push && !job_full),
		.wdata (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.rdata (job_rdata),
		.empty (job_empty)
	);

	assign job_out = swma_pkg::job_t'(job_rdata);

	// Back: divide, clamp, and hold the result word for the receiver.
	swma_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!job_empty),
		.job_pop  (job_pop),
		.job      (job_out),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

endmodule

[tb/sv/sliding_window_max_average_test.sv]
module sliding_window_max_average_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Ring size of the block and the widths the expected words are built at.
	localparam int WINDOW_SIZE = swma_pkg::WINDOW_MAX_DEF;
	localparam int PTR_W       = $clog2(WINDOW_SIZE);
	localparam int CW          = swma_pkg::CFG_W;
	localparam int SB          = swma_pkg::SAMPLE_BITS;

	// Words of top, then bottom samples that carry the running sum past the
	// bottom of its range once the length is raised mid-stream.
	localparam int WRAP_WORDS  = WINDOW_SIZE / 2 + 1;
	// Words sent into a long window that never fills before the length drops.
	localparam int CUT_WORDS   = 64;

	// Window lengths with a special meaning: zero counts as one, anything past
	// the ring size counts as the ring size.
	localparam logic [CW-1:0] LEN_ZERO     = '0;
	localparam logic [CW-1:0] LEN_ONE      = CW'(1);
	localparam logic [CW-1:0] LEN_WRAP     = CW'(WRAP_WORDS);
	localparam logic [CW-1:0] LEN_FULL     = CW'(WINDOW_SIZE);
	localparam logic [CW-1:0] LEN_OVER     = CW'(WINDOW_SIZE + 1);
	localparam logic [CW-1:0] LEN_CODE_TOP = '1;

	localparam logic signed [SB-1:0] SAMPLE_TOP    = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SAMPLE_BOTTOM = {1'b1, {(SB-1){1'b0}}};

	// Idle time before a length write, once every owed result is in: lets the front
	// end finish a word that closes no stream.
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_WORDS   = 48;
	localparam int CYCLE_LIMIT   = 1_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CW-1:0]     cfg_data = swma_pkg::CFG_RESET;
	logic              in_valid = 1'b0;
	logic              in_ready;
	swma_pkg::in_t     in_word = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	swma_pkg::out_t    out_word;

	sliding_window_max_average DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	always #1 clk = ~clk;

	// Shadow copy of the block's stream state, advanced on every accepted word.
	logic [CW-1:0]                      window_len = swma_pkg::CFG_RESET;
	logic signed [SB-1:0]               ring [WINDOW_SIZE];
	logic [PTR_W-1:0]                   ring_ptr = '0;
	logic [CW-1:0]                      filled = '0;
	logic signed [swma_pkg::SUM_W-1:0]  running_sum = '0;
	logic signed [swma_pkg::SUM_W-1:0]  peak_sum = '0;
	bit                                 peak_seen = 1'b0;

	// Results still owed by the block, oldest first.
	swma_pkg::out_t pending_results[$];

	int failures = 0;
	int words_sent = 0;
	int results_checked = 0;
	int short_results = 0;
	int settings_written = 0;
	int cycles = 0;

	// Idle percentages for the sender and the receiver.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Words still to send in the open random stream; zero means none is open.
	int words_left = 0;

	function automatic int span_of(logic [CW-1:0] len);
		if (len == LEN_ZERO)
			return 1;
		if (len > LEN_FULL)
			return WINDOW_SIZE;
		return int'(len);
	endfunction

	// Fold one accepted word into the shadow window and queue the result the
	// block owes when the word closes a stream.
	task automatic fold_sample(swma_pkg::in_t w);
		int             span;
		longint         wide_sum;
		longint         average;
		swma_pkg::out_t owed;
		span = span_of(window_len);
		wide_sum = longint'(running_sum) + longint'(w.sample);
		// Drop the word that leaves the window once the window is full.
		if (int'(filled) >= span)
			wide_sum -= longint'(ring[ring_ptr - PTR_W'(span)]);
		ring[ring_ptr] = w.sample;
		ring_ptr = ring_ptr + 1'b1;
		if (int'(filled) < WINDOW_SIZE)
			filled = filled + 1'b1;
		// Wrap within the sum width, as the hardware accumulator does.
		running_sum = wide_sum[swma_pkg::SUM_W-1:0];
		if (int'(filled) >= span) begin
			if (!peak_seen || running_sum > peak_sum)
				peak_sum = running_sum;
			peak_seen = 1'b1;
		end
		if (!w.last)
			return;
		owed = '0;
		if (peak_seen) begin
			average = (longint'(peak_sum) * (longint'(1) << swma_pkg::FRAC_W))
				/ longint'(span);
			if (average > longint'(signed'(swma_pkg::AVG_POS_MAX)))
				average = longint'(signed'(swma_pkg::AVG_POS_MAX));
			if (average < longint'(signed'(swma_pkg::AVG_NEG_MIN)))
				average = longint'(signed'(swma_pkg::AVG_NEG_MIN));
			owed.max_sum = peak_sum;
			owed.max_average = average[swma_pkg::AVG_W-1:0];
		end else begin
			owed.short_stream = 1'b1;
		end
		pending_results.insert(pending_results.size(), owed);
		// Start the next stream from an empty window.
		ring_ptr = '0;
		filled = '0;
		running_sum = '0;
		peak_sum = '0;
		peak_seen = 1'b0;
	endtask

	// Offer one sample word, idling first at the sender's rate, and hold it
	// until the block takes it.
	task automatic push_word(logic signed [SB-1:0] value, logic closes);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= '{sample: value, last: closes};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		fold_sample('{sample: value, last: closes});
		words_sent++;
	endtask

	// Drop valid, wait for every owed result, then let the back end go quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the window length; only called while the block is idle.
	task automatic write_length(logic [CW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		window_len = value;
		settings_written++;
	endtask

	// Extremes, small values near zero and plain random words.
	function automatic logic signed [SB-1:0] pick_sample();
		case ($urandom_range(9))
			0: return SAMPLE_TOP;
			1: return SAMPLE_BOTTOM;
			2, 3: return SB'($signed($urandom_range(64)) - 32);
			default: return SB'($urandom);
		endcase
	endfunction

	// Mostly short windows; now and then a long one or a code that gets clamped.
	function automatic logic [CW-1:0] pick_length();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return LEN_ZERO;
		if (roll < 9)
			return CW'($urandom_range(int'(LEN_CODE_TOP), int'(LEN_OVER)));
		if (roll < 13)
			return LEN_FULL;
		if (roll < 25)
			return CW'($urandom_range(128, 17));
		return CW'($urandom_range(16, 1));
	endfunction

	// Send the next word of the open random stream, opening a new one when
	// needed. Most streams cover at least one full window; some end early.
	task automatic push_stream_word();
		int span;
		if (words_left == 0) begin
			span = span_of(window_len);
			if (span > 1 && $urandom_range(99) < 15)
				words_left = $urandom_range(span - 1, 1);
			else
				words_left = $urandom_range(2 * span + 8, span);
		end
		words_left--;
		push_word(pick_sample(), words_left == 0);
	endtask

	// Reset value of the length, clamped codes, short streams, truncation of
	// negative averages and both ends of the sample range.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// Length one straight out of reset: a single word is a full window.
		push_word(SAMPLE_TOP, 1'b1);
		push_word(SAMPLE_BOTTOM, 1'b1);
		settle();
		write_length(LEN_ZERO);
		push_word(16'sd5, 1'b0);
		push_word(-16'sd3, 1'b0);
		push_word(16'sd7, 1'b1);
		settle();
		write_length(CW'(3));
		push_word(16'sd1, 1'b0);
		push_word(16'sd2, 1'b1);
		push_word(-16'sd1, 1'b0);
		push_word(16'sd0, 1'b0);
		push_word(16'sd0, 1'b1);
		push_word(16'sd1, 1'b0);
		push_word(16'sd0, 1'b0);
		push_word(16'sd0, 1'b0);
		push_word(16'sd4, 1'b1);
		settle();
		write_length(CW'(2));
		push_word(SAMPLE_TOP, 1'b0);
		push_word(SAMPLE_TOP, 1'b1);
		push_word(SAMPLE_BOTTOM, 1'b0);
		push_word(SAMPLE_BOTTOM, 1'b1);
		push_word(-16'sd1, 1'b0);
		push_word(16'sd0, 1'b1);
		settle();
		write_length(LEN_CODE_TOP);
		push_word(16'sd9, 1'b1);
		settle();
	endtask

	// Random streams under each idling pattern. A phase may stop inside a
	// stream, so the next length write lands mid-stream.
	task automatic test_random_streams();
		int send_pct [4] = '{0, 78, 0, 32};
		int stall_pct [4] = '{0, 0, 78, 32};
		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct = send_pct[mode];
			recv_stall_pct = stall_pct[mode];
			for (int phase = 0; phase < 3; phase++) begin
				settle();
				write_length(pick_length());
				// Send the phase's words, idling at the sender's rate between them.
				repeat (PHASE_WORDS) push_stream_word();
			end
		end
		if (words_left != 0) begin
			words_left = 0;
			push_word(pick_sample(), 1'b1);
		end
		settle();
	endtask

	// Length writes inside a stream: top samples at length one, then bottom
	// samples at a longer length, each dropping a top sample, drive the sum
	// below its range so it wraps high and the average saturates high. Then
	// long windows that never fill before the length drops to one saturate
	// the average high and low.
	task automatic test_length_change();
		send_idle_pct = 32;
		recv_stall_pct = 32;
		write_length(LEN_ONE);
		repeat (WRAP_WORDS) push_word(SAMPLE_TOP, 1'b0);
		settle();
		write_length(LEN_WRAP);
		repeat (WRAP_WORDS - 1) push_word(SAMPLE_BOTTOM, 1'b0);
		push_word(SAMPLE_BOTTOM, 1'b1);
		settle();
		write_length(LEN_FULL);
		repeat (CUT_WORDS) push_word(SAMPLE_TOP, 1'b0);
		settle();
		write_length(LEN_ONE);
		push_word(SAMPLE_TOP, 1'b1);
		settle();
		write_length(LEN_FULL);
		repeat (CUT_WORDS) push_word(SAMPLE_BOTTOM, 1'b0);
		settle();
		write_length(LEN_ONE);
		push_word(SAMPLE_BOTTOM, 1'b1);
		settle();
	endtask

	// Take result words at the receiver's rate and check each one against the
	// oldest owed result.
	always @(posedge clk) begin
		swma_pkg::out_t owed;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with no stream closed: %p", out_word);
				failures++;
			end else begin
				owed = pending_results.pop_front();
				results_checked++;
				if (owed.short_stream)
					short_results++;
				if (out_word.max_sum !== owed.max_sum) begin
					$error("max_sum: expected %0d, got %0d", owed.max_sum, out_word.max_sum);
					failures++;
				end
				if (out_word.max_average !== owed.max_average) begin
					$error("max_average: expected %0d, got %0d",
						owed.max_average, out_word.max_average);
					failures++;
				end
				if (out_word.short_stream !== owed.short_stream) begin
					$error("short_stream: expected %0d, got %0d",
						owed.short_stream, out_word.short_stream);
					failures++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < WINDOW_SIZE; i++)
			ring[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_streams();
		test_length_change();

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			failures++;
		end
		$display("Sent %0d sample words over %0d window lengths, idle and stalled at four rates",
			words_sent, settings_written);
		$display("Checked %0d results, %0d of them short streams, in %0d cycles",
			results_checked, short_results, cycles);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
